// File: hdl/alle_pkg.sv
// Shared types and constants for the array linked list engine.
// No dependencies; alle_cfg and the engine import this package.
package alle_pkg;

	// Pool geometry
	localparam int CAPACITY = 16;
	localparam int ELEM_W   = 32;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int PTR_W    = SLOT_W + 1;
	localparam logic [PTR_W-1:0] END_PTR = PTR_W'(CAPACITY);

	// Field widths of the request and result words
	localparam int OP_W     = 3;
	localparam int POS_W    = 5;
	localparam int STATUS_W = 2;
	localparam int IPOS_W   = 4;
	localparam logic [IPOS_W-1:0] IPOS_MAX = '1;

	// Configuration register file
	localparam int CFG_W     = 5;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);
	localparam logic REG_CAPACITY = 1'b0;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_GET    = 3'd2;
	localparam logic [OP_W-1:0] OP_WALK   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  position;
		logic [ELEM_W-1:0] element_in;
	} alle_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ELEM_W-1:0]   element_out;
		logic [IPOS_W-1:0]   item_position;
		logic                item_valid;
		logic                last;
	} alle_out_t;

endpackage

// File: hdl/alle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the element store.
module alle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, held while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/alle_cfg.sv
// APB-style configuration register for the linked list engine.
// Depends on alle_pkg; gives the clamped slot capacity to the sequencer.
module alle_cfg import alle_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [PTR_W-1:0]   cap_eff
);

	logic [CFG_W-1:0] cap_q;
	logic             reg_hit;

	assign reg_hit = (paddr[2] == REG_CAPACITY);
	assign pready  = 1'b1;

	// Capture a write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			cap_q <= pwdata[CFG_W-1:0];
		end
	end

	// Read back
	assign prdata = reg_hit ? PDATA_W'(cap_q) : '0;

	// Clamp to 1 .. CAPACITY
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = PTR_W'(1);
		end else if (int'(cap_q) > CAPACITY) begin
			cap_eff = END_PTR;
		end else begin
			cap_eff = PTR_W'(cap_q);
		end
	end

endmodule

// File: hdl/array_linked_list_engine.sv
// Linked list engine: one request at a time, stepped by one link lookup per cycle. Insert scans
// for the lowest free slot below the capacity, then at position p > 0 hops to p - 1 and splices;
// it overflows when no slot is free. Remove and get hop to their position; a walk reads and hands
// out one element after another, held while the output stalls. Clear, empty walk and rejected
// requests give a single status word. The last result may still wait in the output register.
// Reset empties the list and frees every slot; capacity returns to 16; element store not reset.
module array_linked_list_engine import alle_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  alle_in_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output alle_out_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// Sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CHECK    = 4'd1;
	localparam logic [3:0] S_SCAN     = 4'd2;
	localparam logic [3:0] S_HOP      = 4'd3;
	localparam logic [3:0] S_INS_LINK = 4'd4;
	localparam logic [3:0] S_REM_SEL  = 4'd5;
	localparam logic [3:0] S_REM_LINK = 4'd6;
	localparam logic [3:0] S_RD       = 4'd7;
	localparam logic [3:0] S_OUT      = 4'd8;
	localparam logic [3:0] S_RESP     = 4'd9;

	logic [3:0]          state_q;
	logic [OP_W-1:0]     op_q;
	logic [POS_W-1:0]    pos_q;
	logic [ELEM_W-1:0]   elem_q;
	logic [PTR_W-1:0]    cur_q;
	logic [PTR_W-1:0]    prev_q;
	logic [PTR_W-1:0]    slot_q;
	logic [PTR_W-1:0]    scan_q;
	logic [POS_W-1:0]    cnt_q;
	logic [POS_W-1:0]    target_q;
	logic [IPOS_W-1:0]   idx_q;
	logic [STATUS_W-1:0] status_q;

	logic [CAPACITY-1:0] used_q;
	logic [PTR_W-1:0]    next_q [CAPACITY];
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    count_q;

	logic                out_valid_q;
	alle_out_t           out_q;

	logic [PTR_W-1:0]    cap_eff;
	logic [PTR_W-1:0]    nxt;
	logic                accept;
	logic                out_free;
	logic                out_load;
	logic                scan_found;
	logic                walk_last;
	logic                ram_wr_en;
	logic                ram_rd_en;
	logic [ELEM_W-1:0]   ram_rd_data;

	alle_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap_eff (cap_eff)
	);

	alle_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (scan_q[SLOT_W-1:0]),
		.wr_data (elem_q),
		.rd_en   (ram_rd_en),
		.rd_addr (cur_q[SLOT_W-1:0]),
		.rd_data (ram_rd_data)
	);

	// Handshake
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = ((state_q == S_OUT) || (state_q == S_RESP)) && out_free;

	// Shared link lookup and scan test
	assign nxt        = next_q[cur_q[SLOT_W-1:0]];
	assign scan_found = (scan_q < cap_eff) && !used_q[scan_q[SLOT_W-1:0]];
	assign walk_last  = (nxt == END_PTR) || (idx_q == IPOS_MAX);
	assign ram_wr_en  = (state_q == S_SCAN) && scan_found;
	assign ram_rd_en  = (state_q == S_RD);

	// Sequencer and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				next_q[i] <= END_PTR;
			end
			head_q      <= END_PTR;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result word once taken
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					cur_q <= head_q;
					cnt_q <= '0;
					idx_q <= '0;
					case (op_q)
						OP_INSERT: begin
							if (6'(pos_q) > 6'(count_q)) begin
								status_q <= ST_INVALID;
								state_q  <= S_RESP;
							end else begin
								scan_q  <= '0;
								state_q <= S_SCAN;
							end
						end
						OP_REMOVE: begin
							target_q <= pos_q - POS_W'(1);
							if (6'(pos_q) >= 6'(count_q)) begin
								status_q <= ST_INVALID;
								state_q  <= S_RESP;
							end else if (pos_q == '0) begin
								state_q <= S_REM_LINK;
							end else begin
								state_q <= S_HOP;
							end
						end
						OP_GET: begin
							target_q <= pos_q;
							if (6'(pos_q) >= 6'(count_q)) begin
								status_q <= ST_INVALID;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_HOP;
							end
						end
						OP_WALK: begin
							if (head_q == END_PTR) begin
								status_q <= ST_OK;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_RD;
							end
						end
						OP_CLEAR: begin
							used_q <= '0;
							for (int i = 0; i < CAPACITY; i++) begin
								next_q[i] <= END_PTR;
							end
							head_q   <= END_PTR;
							count_q  <= '0;
							status_q <= ST_OK;
							state_q  <= S_RESP;
						end
						default: begin
							status_q <= ST_INVALID;
							state_q  <= S_RESP;
						end
					endcase
				end
				// look for the lowest free slot, one per cycle
				S_SCAN: begin
					if (scan_q >= cap_eff) begin
						status_q <= ST_OVERFLOW;
						state_q  <= S_RESP;
					end else if (scan_found) begin
						slot_q <= scan_q;
						if (pos_q == '0) begin
							used_q[scan_q[SLOT_W-1:0]] <= 1'b1;
							next_q[scan_q[SLOT_W-1:0]] <= head_q;
							head_q   <= scan_q;
							count_q  <= count_q + PTR_W'(1);
							status_q <= ST_OK;
							state_q  <= S_RESP;
						end else begin
							target_q <= pos_q - POS_W'(1);
							state_q  <= S_HOP;
						end
					end else begin
						scan_q <= scan_q + PTR_W'(1);
					end
				end
				// follow links until the target position
				S_HOP: begin
					if (cnt_q == target_q) begin
						case (op_q)
							OP_INSERT: state_q <= S_INS_LINK;
							OP_REMOVE: state_q <= S_REM_SEL;
							default:   state_q <= S_RD;
						endcase
					end else begin
						cur_q <= nxt;
						cnt_q <= cnt_q + POS_W'(1);
					end
				end
				// splice the new slot after the current one
				S_INS_LINK: begin
					used_q[slot_q[SLOT_W-1:0]] <= 1'b1;
					next_q[slot_q[SLOT_W-1:0]] <= nxt;
					next_q[cur_q[SLOT_W-1:0]]  <= slot_q;
					count_q  <= count_q + PTR_W'(1);
					status_q <= ST_OK;
					state_q  <= S_RESP;
				end
				// step onto the victim, keep its predecessor
				S_REM_SEL: begin
					prev_q  <= cur_q;
					cur_q   <= nxt;
					state_q <= S_REM_LINK;
				end
				// unlink and free the victim
				S_REM_LINK: begin
					if (pos_q == '0) begin
						head_q <= nxt;
					end else begin
						next_q[prev_q[SLOT_W-1:0]] <= nxt;
					end
					used_q[cur_q[SLOT_W-1:0]] <= 1'b0;
					next_q[cur_q[SLOT_W-1:0]] <= END_PTR;
					count_q  <= count_q - PTR_W'(1);
					status_q <= ST_OK;
					state_q  <= S_RESP;
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				// hand out an element for get or walk
				S_OUT: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.status        <= ST_OK;
						out_q.element_out   <= ram_rd_data;
						out_q.item_valid    <= 1'b1;
						if (op_q == OP_WALK) begin
							out_q.item_position <= idx_q;
							out_q.last          <= walk_last;
							if (walk_last) begin
								state_q <= S_IDLE;
							end else begin
								cur_q   <= nxt;
								idx_q   <= idx_q + IPOS_W'(1);
								state_q <= S_RD;
							end
						end else begin
							out_q.item_position <= '0;
							out_q.last          <= 1'b1;
							state_q             <= S_IDLE;
						end
					end
				end
				// single status word
				S_RESP: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.status        <= status_q;
						out_q.element_out   <= '0;
						out_q.item_position <= '0;
						out_q.item_valid    <= 1'b0;
						out_q.last          <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the request word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_data.op;
			pos_q  <= in_data.position;
			elem_q <= in_data.element_in;
		end
	end

	// Occupied slots always match the element count
	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(count_q))
		else $error("used slot count differs from element count");

	// Empty list has no head and vice versa
	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (head_q == END_PTR))
		else $error("head pointer and element count disagree");

	// Count never exceeds the pool
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= CAPACITY)
		else $error("element count beyond capacity");

	// An accepted word always enters decode next
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_CHECK))
		else $error("accepted word not decoded");

	// A result is loaded only when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result word lost");

endmodule
